/* sv/tsf_pkg.sv */
// shared types and constants for the scanline triangle fill block
`default_nettype none

package tsf_pkg;

  localparam int TSF_COORD_BITS = 12;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_EMIT
  } tsf_state_t;

  typedef enum logic [1:0] {
    EK_SPAN,
    EK_FLAT,
    EK_IDLE
  } tsf_emit_t;

  typedef struct packed {
    logic      load_start;
    logic      div_start;
    logic      div_step;
    logic      emit;
    tsf_emit_t emit_kind;
  } tsf_cmd_t;

  typedef struct packed {
    logic active;
    logic flat;
  } tsf_status_t;

endpackage

`default_nettype wire

/* sv/tsf_div.sv */
// iterative signed divider, truncating toward zero, one quotient bit per step
`default_nettype none

module tsf_div import tsf_pkg::*; #(
  parameter int COORD_BITS = TSF_COORD_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        start,
  input  wire logic                        step,
  input  wire logic signed [2*COORD_BITS:0] dividend,
  input  wire logic [COORD_BITS-1:0]       divisor,
  output logic signed [COORD_BITS:0]       quotient
);

  localparam int CB    = COORD_BITS;
  localparam int ACC_W = 2 * CB + 1;

  logic [CB-1:0]    rem_r, rem_nxt;
  logic [CB-1:0]    low_r, low_nxt;
  logic [CB-1:0]    div_r, div_nxt;
  logic             neg_r, neg_nxt;
  logic             dz_r, dz_nxt;
  logic [ACC_W-1:0] mag;
  logic [CB:0]      trial;
  logic [CB:0]      diff;
  logic             ge;

  // magnitude stays below 2^(2*CB) and its upper half below the divisor
  assign mag   = dividend[ACC_W-1] ? (~dividend + ACC_W'(1)) : dividend;
  assign trial = {rem_r, low_r[CB-1]};
  assign ge    = (trial >= {1'b0, div_r});
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    rem_nxt = rem_r;
    low_nxt = low_r;
    div_nxt = div_r;
    neg_nxt = neg_r;
    dz_nxt  = dz_r;
    if (start) begin
      rem_nxt = mag[2*CB-1:CB];
      low_nxt = mag[CB-1:0];
      div_nxt = divisor;
      neg_nxt = dividend[ACC_W-1];
      dz_nxt  = (divisor == '0);
    end else if (step) begin
      rem_nxt = ge ? diff[CB-1:0] : trial[CB-1:0];
      low_nxt = {low_r[CB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    dz_r  <= dz_nxt;
  end

  always_comb begin
    if (dz_r) begin
      quotient = '0;
    end else if (neg_r) begin
      quotient = -$signed({1'b0, low_r});
    end else begin
      quotient = $signed({1'b0, low_r});
    end
  end

endmodule

`default_nettype wire

/* sv/tsf_datapath.sv */
// vertex sort, edge accumulators, dividers and span output register
`default_nettype none

module tsf_datapath import tsf_pkg::*; #(
  parameter int COORD_BITS = TSF_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire tsf_cmd_t                     cmd,
  output tsf_status_t                       status,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_a_x,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_a_y,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_b_x,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_b_y,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_c_x,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_c_y,
  input  wire logic [15:0]                  in_pixel_color,
  output logic signed [COORD_BITS-1:0]      out_span_x,
  output logic signed [COORD_BITS-1:0]      out_span_y,
  output logic [COORD_BITS:0]               out_span_length,
  output logic [15:0]                       out_span_color,
  output logic                              out_last_span,
  output logic                              out_idle_flag
);

  localparam int CB    = COORD_BITS;
  localparam int ACC_W = 2 * CB + 1;

  logic signed [CB-1:0]    vx0_r, vx1_r, vx2_r, vy0_r, vy1_r, vy2_r;
  logic signed [CB-1:0]    sx0, sx1, sx2, sy0, sy1, sy2;
  logic signed [CB-1:0]    row_r;
  logic [15:0]             color_r;
  logic                    lower_r;
  logic                    active_r;
  logic signed [ACC_W-1:0] lacc_r, racc_r;

  logic signed [CB-1:0]    ox_r, oy_r;
  logic [CB:0]             olen_r;
  logic [15:0]             ocolor_r;
  logic                    olast_r, oidle_r;

  logic [CB:0]             h01, h12, h02;
  logic [CB:0]             dx01, dx12, dx02;
  logic [CB:0]             dxl;
  logic signed [CB:0]      ql, qr;
  logic signed [CB-1:0]    xbase;
  logic signed [CB+1:0]    span_a, span_b, lo, hi;
  logic [CB+1:0]           len_w;
  logic signed [CB-1:0]    minx, maxx;
  logic [CB:0]             row_inc;
  logic                    last_row;
  logic                    to_lower;

  // stable compare-swap network on y: 0/1, 1/2, 0/1
  always_comb begin
    logic signed [CB-1:0] x0, x1, x2, y0, y1, y2, tx, ty;
    tx = '0; ty = '0;
    x0 = in_vertex_a_x; y0 = in_vertex_a_y;
    x1 = in_vertex_b_x; y1 = in_vertex_b_y;
    x2 = in_vertex_c_x; y2 = in_vertex_c_y;
    if (y0 > y1) begin
      tx = x0; ty = y0; x0 = x1; y0 = y1; x1 = tx; y1 = ty;
    end
    if (y1 > y2) begin
      tx = x1; ty = y1; x1 = x2; y1 = y2; x2 = tx; y2 = ty;
    end
    if (y0 > y1) begin
      tx = x0; ty = y0; x0 = x1; y0 = y1; x1 = tx; y1 = ty;
    end
    sx0 = x0; sx1 = x1; sx2 = x2;
    sy0 = y0; sy1 = y1; sy2 = y2;
  end

  assign h01  = {vy1_r[CB-1], vy1_r} - {vy0_r[CB-1], vy0_r};
  assign h12  = {vy2_r[CB-1], vy2_r} - {vy1_r[CB-1], vy1_r};
  assign h02  = {vy2_r[CB-1], vy2_r} - {vy0_r[CB-1], vy0_r};
  assign dx01 = {vx1_r[CB-1], vx1_r} - {vx0_r[CB-1], vx0_r};
  assign dx12 = {vx2_r[CB-1], vx2_r} - {vx1_r[CB-1], vx1_r};
  assign dx02 = {vx2_r[CB-1], vx2_r} - {vx0_r[CB-1], vx0_r};
  assign dxl  = lower_r ? dx12 : dx01;

  tsf_div #(.COORD_BITS(CB)) u_div_left (
    .clk      (clk),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (lacc_r),
    .divisor  (lower_r ? h12[CB-1:0] : h01[CB-1:0]),
    .quotient (ql)
  );

  tsf_div #(.COORD_BITS(CB)) u_div_right (
    .clk      (clk),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (racc_r),
    .divisor  (h02[CB-1:0]),
    .quotient (qr)
  );

  assign xbase  = lower_r ? vx1_r : vx0_r;
  assign span_a = {{2{xbase[CB-1]}}, xbase} + {ql[CB], ql};
  assign span_b = {{2{vx0_r[CB-1]}}, vx0_r} + {qr[CB], qr};

  always_comb begin
    minx = vx0_r;
    maxx = vx0_r;
    if (vx1_r < minx) minx = vx1_r;
    if (vx1_r > maxx) maxx = vx1_r;
    if (vx2_r < minx) minx = vx2_r;
    if (vx2_r > maxx) maxx = vx2_r;
  end

  always_comb begin
    if (cmd.emit_kind == EK_FLAT) begin
      lo = {{2{minx[CB-1]}}, minx};
      hi = {{2{maxx[CB-1]}}, maxx};
    end else if (span_a > span_b) begin
      lo = span_b;
      hi = span_a;
    end else begin
      lo = span_a;
      hi = span_b;
    end
  end

  assign len_w    = hi - lo + (CB+2)'(1);
  assign last_row = (row_r == vy2_r);
  assign row_inc  = {row_r[CB-1], row_r} + (CB+1)'(1);
  // upper part ends one row above y1 unless the bottom edge is flat
  assign to_lower = !lower_r && (row_inc == {vy1_r[CB-1], vy1_r}) && (vy1_r != vy2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      lower_r  <= 1'b0;
    end else if (cmd.load_start) begin
      active_r <= (sy0 != sy2);
      lower_r  <= (sy0 == sy1);
    end else if (cmd.emit && cmd.emit_kind == EK_SPAN) begin
      if (last_row) active_r <= 1'b0;
      if (to_lower) lower_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      vx0_r   <= sx0;
      vx1_r   <= sx1;
      vx2_r   <= sx2;
      vy0_r   <= sy0;
      vy1_r   <= sy1;
      vy2_r   <= sy2;
      color_r <= in_pixel_color;
      row_r   <= sy0;
      lacc_r  <= '0;
      racc_r  <= '0;
    end else if (cmd.emit && cmd.emit_kind == EK_SPAN) begin
      row_r  <= row_inc[CB-1:0];
      lacc_r <= to_lower ? '0 : lacc_r + {{(ACC_W-CB-1){dxl[CB]}}, dxl};
      racc_r <= racc_r + {{(ACC_W-CB-1){dx02[CB]}}, dx02};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_kind)
        EK_SPAN: begin
          ox_r     <= lo[CB-1:0];
          oy_r     <= row_r;
          olen_r   <= len_w[CB:0];
          ocolor_r <= color_r;
          olast_r  <= last_row;
          oidle_r  <= 1'b0;
        end
        EK_FLAT: begin
          ox_r     <= lo[CB-1:0];
          oy_r     <= vy0_r;
          olen_r   <= len_w[CB:0];
          ocolor_r <= color_r;
          olast_r  <= 1'b1;
          oidle_r  <= 1'b0;
        end
        default: begin
          ox_r     <= '0;
          oy_r     <= '0;
          olen_r   <= '0;
          ocolor_r <= '0;
          olast_r  <= 1'b0;
          oidle_r  <= 1'b1;
        end
      endcase
    end
  end

  assign status.active = active_r;
  assign status.flat   = (vy0_r == vy2_r);

  assign out_span_x      = ox_r;
  assign out_span_y      = oy_r;
  assign out_span_length = olen_r;
  assign out_span_color  = ocolor_r;
  assign out_last_span   = olast_r;
  assign out_idle_flag   = oidle_r;

endmodule

`default_nettype wire

/* sv/tsf_ctrl.sv */
// sequencing state machine: accept, setup, division steps, span emit
`default_nettype none

module tsf_ctrl import tsf_pkg::*; #(
  parameter int COORD_BITS = TSF_COORD_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_action,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire tsf_status_t status,
  output tsf_cmd_t         cmd
);

  localparam int CNT_W = $clog2(COORD_BITS);

  tsf_state_t       state_r, state_nxt;
  tsf_emit_t        kind_r, kind_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_action) begin
            state_nxt = S_SETUP;
          end else if (status.active) begin
            state_nxt = S_DIV;
            kind_nxt  = EK_SPAN;
            cnt_nxt   = '0;
          end else begin
            state_nxt = S_EMIT;
            kind_nxt  = EK_IDLE;
          end
        end
      end
      S_SETUP: begin
        if (status.flat) begin
          state_nxt = S_EMIT;
          kind_nxt  = EK_FLAT;
        end else begin
          state_nxt = S_DIV;
          kind_nxt  = EK_SPAN;
          cnt_nxt   = '0;
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(COORD_BITS - 1)) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    cmd.emit_kind = kind_r;
    in_stall      = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall       = 1'b0;
        cmd.load_start = in_valid && !in_action;
        cmd.div_start  = in_valid && in_action && status.active;
      end
      S_SETUP: begin
        cmd.div_start = !status.flat;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = slot_free;
      end
      default: ;
    endcase
  end

  // output beat register stays valid until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= EK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* sv/triangle_scanline_fill.sv */
// a span request passes the division steps, then emit, before its beat is registered;
// a start item passes setup first, a flat start goes from setup to emit, and a request
// with no triangle goes straight to emit; the two dividers retire one quotient bit per
// cycle; a new item is taken once the last has left emit, even while its beat waits
// reset: synchronous active low, clears the sequencer, the active triangle and out_valid
`default_nettype none

module triangle_scanline_fill import tsf_pkg::*; #(
  parameter int COORD_BITS = TSF_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_action,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_a_x,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_a_y,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_b_x,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_b_y,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_c_x,
  input  wire logic signed [COORD_BITS-1:0] in_vertex_c_y,
  input  wire logic [15:0]                  in_pixel_color,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [COORD_BITS-1:0]      out_span_x,
  output logic signed [COORD_BITS-1:0]      out_span_y,
  output logic [COORD_BITS:0]               out_span_length,
  output logic [15:0]                       out_span_color,
  output logic                              out_last_span,
  output logic                              out_idle_flag
);

  tsf_cmd_t    cmd;
  tsf_status_t status;

  tsf_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tsf_datapath #(.COORD_BITS(COORD_BITS)) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_vertex_a_x   (in_vertex_a_x),
    .in_vertex_a_y   (in_vertex_a_y),
    .in_vertex_b_x   (in_vertex_b_x),
    .in_vertex_b_y   (in_vertex_b_y),
    .in_vertex_c_x   (in_vertex_c_x),
    .in_vertex_c_y   (in_vertex_c_y),
    .in_pixel_color  (in_pixel_color),
    .out_span_x      (out_span_x),
    .out_span_y      (out_span_y),
    .out_span_length (out_span_length),
    .out_span_color  (out_span_color),
    .out_last_span   (out_last_span),
    .out_idle_flag   (out_idle_flag)
  );

`ifndef SYNTHESIS
  a_idle_beat_only_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_kind == EK_IDLE) |-> !status.active)
    else $error("idle beat emitted with a triangle active");

  a_span_beat_only_active: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_kind == EK_SPAN) |-> status.active)
    else $error("span beat emitted with no triangle active");

  a_idle_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_idle_flag && out_last_span))
    else $error("beat flagged both idle and last");

  a_start_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_action) |=> (!cmd.emit && !cmd.div_step && in_stall))
    else $error("start item skipped its setup cycle");
`endif

endmodule

`default_nettype wire

/* dv/tsf_tb_pkg.sv */
// coordinate types and action codes shared by the triangle fill testbench files
package tsf_tb_pkg;

  typedef logic signed [tsf_pkg::TSF_COORD_BITS-1:0] coord_t;
  typedef logic [tsf_pkg::TSF_COORD_BITS:0]          span_len_t;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_NEXT  = 1'b1
  } tsf_action_t;

endpackage

/* dv/tsf_span_checker.sv */
// span predictor and scoreboard that watches both channels of the triangle fill block
module tsf_span_checker import tsf_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  coord_t      in_vertex_a_x,
  input  coord_t      in_vertex_a_y,
  input  coord_t      in_vertex_b_x,
  input  coord_t      in_vertex_b_y,
  input  coord_t      in_vertex_c_x,
  input  coord_t      in_vertex_c_y,
  input  logic [15:0] in_pixel_color,
  input  logic        out_valid,
  input  logic        out_stall,
  input  coord_t      out_span_x,
  input  coord_t      out_span_y,
  input  span_len_t   out_span_length,
  input  logic [15:0] out_span_color,
  input  logic        out_last_span,
  input  logic        out_idle_flag,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    coord_t      x;
    coord_t      y;
    span_len_t   len;
    logic [15:0] color;
    logic        last;
    logic        idle;
  } span_beat_t;

  // rasterizer state as the block should hold it
  coord_t      tri_vx [3];
  coord_t      tri_vy [3];
  int          left_acc;
  int          right_acc;
  int          row;
  logic        lower_part;
  logic        tri_live;
  logic [15:0] fill_color;
  span_beat_t  span_q[$];

  function automatic int div_trunc(input int n, input int d);
    return (d == 0) ? 0 : n / d;
  endfunction

  // last row of the upper part; it takes row y1 only when the bottom is flat
  function automatic int upper_end();
    return (tri_vy[1] == tri_vy[2]) ? int'(tri_vy[1]) : int'(tri_vy[1]) - 1;
  endfunction

  function automatic span_beat_t span_of(input int a, input int b, input int r,
                                         input logic fin);
    span_beat_t s;
    int t;
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    s.x     = coord_t'(a);
    s.y     = coord_t'(r);
    s.len   = span_len_t'(b - a + 1);
    s.color = fill_color;
    s.last  = fin;
    s.idle  = 1'b0;
    return s;
  endfunction

  function automatic span_beat_t next_row();
    int x0, x1, x2, y0, y1, y2, a, b;
    logic fin;
    span_beat_t s;
    x0 = tri_vx[0];
    x1 = tri_vx[1];
    x2 = tri_vx[2];
    y0 = tri_vy[0];
    y1 = tri_vy[1];
    y2 = tri_vy[2];
    fin = (row >= y2);
    if (!lower_part) begin
      a = x0 + div_trunc(left_acc, y1 - y0);
      left_acc += x1 - x0;
    end else begin
      a = x1 + div_trunc(left_acc, y2 - y1);
      left_acc += x2 - x1;
    end
    b = x0 + div_trunc(right_acc, y2 - y0);
    right_acc += x2 - x0;
    s = span_of(a, b, row, fin);
    row++;
    if (!lower_part && row > upper_end()) begin
      lower_part = 1'b1;
      left_acc   = (x2 - x1) * (row - y1);
      right_acc  = (x2 - x0) * (row - y0);
    end
    if (fin) tri_live = 1'b0;
    return s;
  endfunction

  function automatic span_beat_t start_triangle(input coord_t ax, input coord_t ay,
                                                input coord_t bx, input coord_t by,
                                                input coord_t cx, input coord_t cy,
                                                input logic [15:0] col);
    coord_t x [3];
    coord_t y [3];
    coord_t t;
    int lo, hi;
    fill_color = col;
    x[0] = ax; y[0] = ay;
    x[1] = bx; y[1] = by;
    x[2] = cx; y[2] = cy;
    // stable pairwise sort by y
    if (y[0] > y[1]) begin
      t = y[0]; y[0] = y[1]; y[1] = t;
      t = x[0]; x[0] = x[1]; x[1] = t;
    end
    if (y[1] > y[2]) begin
      t = y[1]; y[1] = y[2]; y[2] = t;
      t = x[1]; x[1] = x[2]; x[2] = t;
    end
    if (y[0] > y[1]) begin
      t = y[0]; y[0] = y[1]; y[1] = t;
      t = x[0]; x[0] = x[1]; x[1] = t;
    end
    tri_vx     = x;
    tri_vy     = y;
    lower_part = 1'b0;
    left_acc   = 0;
    right_acc  = 0;
    row        = y[0];
    if (y[0] == y[2]) begin
      lo = x[0];
      hi = x[0];
      for (int i = 1; i < 3; i++) begin
        if (x[i] < lo) lo = x[i];
        if (x[i] > hi) hi = x[i];
      end
      tri_live = 1'b0;
      return span_of(lo, hi, row, 1'b1);
    end
    tri_live = 1'b1;
    // flat top goes straight to the lower part
    if (row > upper_end()) begin
      lower_part = 1'b1;
      left_acc   = (int'(x[2]) - int'(x[1])) * (row - int'(y[1]));
    end
    return next_row();
  endfunction

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    span_beat_t got;
    span_beat_t want;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        tri_vx[i] = '0;
        tri_vy[i] = '0;
      end
      left_acc   = 0;
      right_acc  = 0;
      row        = 0;
      lower_part = 1'b0;
      tri_live   = 1'b0;
      fill_color = '0;
      fail_count = 0;
      span_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.x     = out_span_x;
        got.y     = out_span_y;
        got.len   = out_span_length;
        got.color = out_span_color;
        got.last  = out_last_span;
        got.idle  = out_idle_flag;
        if (span_q.size() == 0) begin
          fail_count++;
          $display("%0t: span beat with none expected, got x %0d y %0d len %0d idle %0b",
                   $time, got.x, got.y, got.len, got.idle);
        end else begin
          want = span_q.pop_front();
          check_field("span_x", int'(want.x), int'(got.x));
          check_field("span_y", int'(want.y), int'(got.y));
          check_field("span_length", int'(want.len), int'(got.len));
          check_field("span_color", int'(want.color), int'(got.color));
          check_field("last_span", int'(want.last), int'(got.last));
          check_field("idle_flag", int'(want.idle), int'(got.idle));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_action == ACT_NEXT) begin
          if (!tri_live) begin
            want      = '0;
            want.idle = 1'b1;
          end else begin
            want = next_row();
          end
        end else begin
          want = start_triangle(in_vertex_a_x, in_vertex_a_y, in_vertex_b_x,
                                in_vertex_b_y, in_vertex_c_x, in_vertex_c_y,
                                in_pixel_color);
        end
        span_q.push_back(want);
      end
    end
    pending = span_q.size();
  end

endmodule

/* dv/tb_triangle_scanline_fill.sv */
// stimulus, flow control and verdict for the scanline triangle fill block
module tb_triangle_scanline_fill import tsf_tb_pkg::*;;

  localparam int ITEMS        = 1200;
  localparam int CALM_ITEMS   = 150;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 40;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_action = 1'b0;
  coord_t      in_vertex_a_x = '0;
  coord_t      in_vertex_a_y = '0;
  coord_t      in_vertex_b_x = '0;
  coord_t      in_vertex_b_y = '0;
  coord_t      in_vertex_c_x = '0;
  coord_t      in_vertex_c_y = '0;
  logic [15:0] in_pixel_color = '0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  coord_t      out_span_x;
  coord_t      out_span_y;
  span_len_t   out_span_length;
  logic [15:0] out_span_color;
  logic        out_last_span;
  logic        out_idle_flag;

  int   fail_count;
  int   pending;
  int   items_sent   = 0;
  int   quiet_cycles = 0;
  logic calm         = 1'b0;
  logic rush         = 1'b0;
  logic hold_req     = 1'b0;

  always #4 clk = ~clk;

  triangle_scanline_fill dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_vertex_a_x   (in_vertex_a_x),
    .in_vertex_a_y   (in_vertex_a_y),
    .in_vertex_b_x   (in_vertex_b_x),
    .in_vertex_b_y   (in_vertex_b_y),
    .in_vertex_c_x   (in_vertex_c_x),
    .in_vertex_c_y   (in_vertex_c_y),
    .in_pixel_color  (in_pixel_color),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_span_x      (out_span_x),
    .out_span_y      (out_span_y),
    .out_span_length (out_span_length),
    .out_span_color  (out_span_color),
    .out_last_span   (out_last_span),
    .out_idle_flag   (out_idle_flag)
  );

  tsf_span_checker span_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_vertex_a_x   (in_vertex_a_x),
    .in_vertex_a_y   (in_vertex_a_y),
    .in_vertex_b_x   (in_vertex_b_x),
    .in_vertex_b_y   (in_vertex_b_y),
    .in_vertex_c_x   (in_vertex_c_x),
    .in_vertex_c_y   (in_vertex_c_y),
    .in_pixel_color  (in_pixel_color),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_span_x      (out_span_x),
    .out_span_y      (out_span_y),
    .out_span_length (out_span_length),
    .out_span_color  (out_span_color),
    .out_last_span   (out_last_span),
    .out_idle_flag   (out_idle_flag),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  function automatic int rnd_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int rnd_color();
    return int'($urandom_range(0, 65535));
  endfunction

  // offer one beat and hold it until taken; valid stays high on return
  task automatic send_item(input tsf_action_t act, input int ax, input int ay,
                           input int bx, input int by, input int cx, input int cy,
                           input int col);
    int gap;
    gap = 0;
    if (!calm && !rush && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_vertex_a_x  <= coord_t'(ax);
    in_vertex_a_y  <= coord_t'(ay);
    in_vertex_b_x  <= coord_t'(bx);
    in_vertex_b_y  <= coord_t'(by);
    in_vertex_c_x  <= coord_t'(cx);
    in_vertex_c_y  <= coord_t'(cy);
    in_pixel_color <= 16'(col);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // start beat followed by span requests carrying junk vertex fields
  task automatic send_tri(input int ax, input int ay, input int bx, input int by,
                          input int cx, input int cy, input int col, input int nexts);
    send_item(ACT_START, ax, ay, bx, by, cx, cy, col);
    repeat (nexts)
      send_item(ACT_NEXT, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                rnd_coord(), rnd_coord(), rnd_color());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // result side back-pressure
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        n = LONG_HOLD;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 19);
      end else begin
        out_stall <= 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int pick, h, base, ya, yb, yc, lo_y, hi_y, nexts, cen, r;
    int xa, xb, xc;
    logic hold_done, pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    send_item(ACT_NEXT, 0, 0, 0, 0, 0, 0, 0);              // nothing active yet
    send_tri(-2048, 2047, 2047, 2047, 0, 2047, 'hFFFF, 1); // one flat full-width row
    send_tri(0, 0, 4, 2, -3, 5, 'h0000, 6);                // full run plus an idle request
    send_tri(0, -2048, -5, -2046, 7, -2046, 'hA5A5, 2);    // flat bottom
    send_tri(-2048, 10, 2047, 10, 0, 12, 'h5A5A, 2);       // flat top
    send_tri(2047, 2047, -2048, -2048, 2047, 0, 'h1234, 1);
    send_tri(5, 3, -7, 1, 2, -1, 'h8001, 2);               // drops the tall one mid-way

    while (items_sent < ITEMS) begin
      calm = (items_sent >= ITEMS - CALM_ITEMS);
      if (!hold_done && items_sent >= 300) begin
        // receiver blocks while the sender keeps pushing a tall triangle
        hold_done = 1'b1;
        hold_req  = 1'b1;
        rush      = 1'b1;
        send_tri(rnd_coord(), 100, rnd_coord(), 120, rnd_coord(), 139, rnd_color(), 39);
        rush = 1'b0;
      end
      if (!pause_done && items_sent >= 600) begin
        pause_done = 1'b1;
        drain();
      end
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        send_item(ACT_NEXT, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                  rnd_coord(), rnd_coord(), rnd_color());
      end else if (pick < 4) begin
        ya = rnd_coord();
        send_tri(rnd_coord(), ya, rnd_coord(), ya, rnd_coord(), ya, rnd_color(),
                 $urandom_range(0, 1));
      end else if (pick < 5) begin
        // tall triangle, abandoned after a few rows
        send_tri(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                 rnd_coord(), rnd_color(), $urandom_range(0, 3));
      end else begin
        h    = ($urandom_range(0, 9) == 0) ? 40 : 10;
        base = int'($urandom_range(0, 4095 - h)) - 2048;
        ya   = base + int'($urandom_range(0, h));
        yb   = base + int'($urandom_range(0, h));
        yc   = base + int'($urandom_range(0, h));
        lo_y = (ya < yb) ? ya : yb;
        lo_y = (lo_y < yc) ? lo_y : yc;
        hi_y = (ya > yb) ? ya : yb;
        hi_y = (hi_y > yc) ? hi_y : yc;
        if ($urandom_range(0, 1) == 0) begin
          xa = rnd_coord();
          xb = rnd_coord();
          xc = rnd_coord();
        end else begin
          cen = int'($urandom_range(0, 4095 - 60)) - 2048 + 30;
          xa  = cen + int'($urandom_range(0, 60)) - 30;
          xb  = cen + int'($urandom_range(0, 60)) - 30;
          xc  = cen + int'($urandom_range(0, 60)) - 30;
        end
        nexts = hi_y - lo_y;
        r = $urandom_range(0, 7);
        if (r == 0) nexts = $urandom_range(0, nexts);
        else if (r == 1) nexts = nexts + 1;
        send_tri(xa, ya, xb, yb, xc, yc, rnd_color(), nexts);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
